// File: hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CAP_W-1:0]         cap_t;

  localparam cap_t  CAP_RESET  = cap_t'(16);
  localparam word_t MISS_VALUE = word_t'(-1);
  localparam word_t PUT_VALUE  = word_t'(0);

endpackage

// File: hdl/lkvc_if.sv
// Valid/ready channel interfaces: request, response and configuration.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

interface lkvc_req_if import lkvc_pkg::*; ();
  logic  valid;
  logic  ready;
  op_e   operation;
  word_t lookup_key;
  word_t store_value;

  modport source (output valid, operation, lookup_key, store_value, input ready);
  modport sink   (input valid, operation, lookup_key, store_value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  found;
  word_t read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*; ();
  logic valid;
  logic ready;
  cap_t capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// File: hdl/lru_key_value_cache.sv
// LRU key/value cache top level: fully associative register store.
// Depends on lkvc_pkg and the channel interfaces in lkvc_if.sv.
`timescale 1ns / 1ps
//
// Usage:
//   req_i carries one word per operation: operation (get/put), lookup_key,
//   store_value. rsp_o returns one word per request, in order: found and
//   read_value (stored value or -1 for a get, 0 for a put).
//   cfg_i writes capacity_in_use (0 acts as 1, above DEPTH as DEPTH). It is
//   always ready and unguarded; write it only while no request is in flight.
// Timing:
//   A request is registered on acceptance; from the input register the cache
//   compares all keys, updates all age ranks in parallel and loads the response
//   register. Throughput is 1 word per cycle while rsp_o is not stalled; the
//   combinational key compare and rank update set that rate.
// Reset:
//   Valid marks, the entry count and the valid bits of both pipeline
//   registers clear; the capacity returns to 16. No clearing pass is needed.
// Backpressure:
//   While rsp_o is stalled the held response keeps its value and one more
//   request may wait in the input register; req_i.ready then drops.

module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lkvc_cfg_if.sink      cfg_i,
  lkvc_req_if.sink      req_i,
  lkvc_rsp_if.source    rsp_o
);

  localparam int unsigned RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  cap_t              cap_q;
  logic              in_vld_q;
  op_e               in_op_q;
  word_t             in_key_q;
  word_t             in_val_q;
  logic              out_vld_q, out_vld_d;
  logic              out_found_q;
  word_t             out_data_q;

  word_t             key_q [DEPTH];
  word_t             val_q [DEPTH];
  logic [RANK_W-1:0] rank_q [DEPTH];
  logic [RANK_W-1:0] rank_d [DEPTH];
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              advance, do_op, upd, is_put, hit, full, wr_key;
  logic [DEPTH-1:0]  hit_vec, evict_vec, free_vec, tgt_vec;
  word_t             hit_val;
  logic [RANK_W-1:0] hit_rank;
  logic [CNT_W-1:0]  promote_rank;
  cap_t              cap_z;

  assign cfg_i.ready = 1'b1;
  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;
  assign do_op       = in_vld_q && advance;
  assign is_put      = (in_op_q == OP_PUT);

  // parallel key compare; valid keys are unique so the hit is one-hot
  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i]   = valid_q[i] && (key_q[i] == in_key_q);
      evict_vec[i] = valid_q[i] && (CNT_W'(rank_q[i]) == (count_q - CNT_W'(1)));
      hit_val      = hit_val | (val_q[i] & {DATA_W{hit_vec[i]}});
      hit_rank     = hit_rank | (rank_q[i] & {RANK_W{hit_vec[i]}});
    end
  end

  assign hit      = |hit_vec;
  assign free_vec = ~valid_q & (valid_q + DEPTH'(1));
  assign cap_z    = (cap_q == '0) ? cap_t'(1) : cap_q;
  assign full     = (CMP_W'(count_q) >= CMP_W'(cap_z)) || (count_q == CNT_W'(DEPTH));

  always_comb begin
    upd          = do_op && (hit || is_put);
    wr_key       = 1'b0;
    tgt_vec      = hit_vec;
    promote_rank = CNT_W'(hit_rank);
    count_d      = count_q;
    if (!hit) begin
      wr_key = 1'b1;
      if (full && (count_q != '0)) begin
        tgt_vec      = evict_vec;
        promote_rank = count_q - CNT_W'(1);
      end else begin
        tgt_vec      = free_vec;
        promote_rank = count_q;
        if (upd) begin
          count_d = count_q + CNT_W'(1);
        end
      end
    end
    valid_d = valid_q;
    for (int i = 0; i < DEPTH; i++) begin
      rank_d[i] = rank_q[i];
      if (upd) begin
        if (tgt_vec[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (valid_q[i] && (CNT_W'(rank_q[i]) < promote_rank)) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end
  end

  assign out_vld_d = advance ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.capacity_in_use;
      end
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      out_vld_q <= out_vld_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_op_q  <= req_i.operation;
      in_key_q <= req_i.lookup_key;
      in_val_q <= req_i.store_value;
    end
    if (do_op) begin
      out_found_q <= hit;
      if (is_put) begin
        out_data_q <= PUT_VALUE;
      end else if (hit) begin
        out_data_q <= hit_val;
      end else begin
        out_data_q <= MISS_VALUE;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      rank_q[i] <= rank_d[i];
      if (upd && tgt_vec[i]) begin
        if (is_put) begin
          val_q[i] <= in_val_q;
        end
        if (wr_key) begin
          key_q[i] <= in_key_q;
        end
      end
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_data_q;

endmodule

// File: hdl/lkvc_checker.sv
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lkvc_checker import lkvc_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  req_valid_i,
  input logic  req_ready_i,
  input logic  rsp_valid_i,
  input logic  rsp_ready_i,
  input logic  rsp_found_i,
  input word_t rsp_read_value_i
);

  logic [2:0] pending_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(req_acc) - 3'(rsp_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i) else $error("rsp valid dropped");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_found_i) && $stable(rsp_read_value_i))
    else $error("stalled rsp word changed");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |->
      (rsp_read_value_i == MISS_VALUE) || (rsp_read_value_i == PUT_VALUE))
    else $error("miss carries a stored value");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 3'd0) else $error("rsp word without request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2) else $error("more than two words in flight");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_found_i      (rsp_o.found),
  .rsp_read_value_i (rsp_o.read_value)
);

// File: tb/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_value_cache: directed and random get/put words
// checked against a behavioral LRU mirror kept in a small scoreboard class.
// Depends on lkvc_pkg, the channel interfaces in lkvc_if.sv and the RTL top level.

module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned POOL_SIZE       = 24;
  localparam int unsigned DRAIN_WAIT      = 4;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES      = 10;

  typedef struct packed {
    logic  found;
    word_t value;
  } reply_t;

  class cache_mirror;
    word_t       keys   [DEPTH];
    word_t       values [DEPTH];
    bit          valid  [DEPTH];
    int unsigned rank   [DEPTH];
    int unsigned count;
    cap_t        capacity;
    reply_t      expected_replies [$];
    int unsigned errors;

    function new();
      capacity = CAP_RESET;
      count    = 0;
      errors   = 0;
      foreach (valid[i]) begin
        valid[i]  = 1'b0;
        rank[i]   = 0;
        keys[i]   = '0;
        values[i] = '0;
      end
    endfunction

    function int unsigned effective_capacity();
      int unsigned c;
      c = capacity;
      if (c > DEPTH) c = DEPTH;
      if (c == 0) c = 1;
      return c;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // slot s becomes most recent; younger entries age by one
    function void promote(int s, int unsigned old_rank);
      for (int i = 0; i < DEPTH; i++) begin
        if (valid[i] && i != s && rank[i] < old_rank) rank[i]++;
      end
      rank[s] = 0;
    endfunction

    function void insert(word_t key, word_t value);
      int          slot;
      int unsigned old_rank;
      slot     = -1;
      old_rank = 0;
      if (count >= effective_capacity()) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (valid[i] && (slot < 0 || rank[i] > old_rank)) begin
            slot     = i;
            old_rank = rank[i];
          end
        end
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot < 0 && !valid[i]) slot = i;
        end
        valid[slot] = 1'b1;
        old_rank    = count;
        count++;
      end
      keys[slot]   = key;
      values[slot] = value;
      promote(slot, old_rank);
    endfunction

    function void apply_request(op_e op, word_t key, word_t value);
      int     hit;
      reply_t r;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (hit < 0 && valid[i] && keys[i] == key) hit = i;
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.value = (op == OP_PUT) ? PUT_VALUE : values[hit];
        promote(hit, rank[hit]);
        if (op == OP_PUT) values[hit] = value;
      end else begin
        r.found = 1'b0;
        r.value = (op == OP_PUT) ? PUT_VALUE : MISS_VALUE;
        if (op == OP_PUT) insert(key, value);
      end
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic found, word_t value);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected response word: found=%0b read_value=%0d",
                 $time, found, value);
      end else begin
        want = expected_replies.pop_front();
        if (found !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, found);
        end
        if (value !== want.value) begin
          errors++;
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, want.value, value);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lkvc_cfg_if cfg_if ();
  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  cache_mirror mirror;
  bit          steady;
  bit          hold_replies;
  word_t       key_pool    [POOL_SIZE];
  word_t       corner_keys [4] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
  cap_t        phase_caps  [NUM_PHASES] = '{5'd31, 5'd5, 5'd1, 5'd16, 5'd2,
                                            5'd17, 5'd0, 5'd8, 5'd3, 5'd16};

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(op_e op, word_t key, word_t value);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.lookup_key  <= key;
    req_if.store_value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    mirror.apply_request(op, key, value);
  endtask

  task automatic send_random();
    word_t       key;
    word_t       value;
    op_e         op;
    int unsigned span;
    int unsigned roll;
    span = mirror.effective_capacity() + 4;
    roll = $urandom_range(0, 99);
    if (roll < 75) key = key_pool[$urandom_range(0, span - 1)];
    else if (roll < 85) key = corner_keys[$urandom_range(0, 3)];
    else key = $urandom;
    if ($urandom_range(0, 9) == 0) value = corner_keys[$urandom_range(0, 3)];
    else value = $urandom;
    op = op_e'($urandom_range(0, 1));
    send_request(op, key, value);
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_capacity(cap_t cap);
    drain_replies();
    @(negedge clk_i);
    cfg_if.valid           <= 1'b1;
    cfg_if.capacity_in_use <= cap;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    mirror.capacity = cap;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(OP_GET, 32'h7fff_ffff, 32'h0);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(OP_PUT, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hffff_ffff);
    send_request(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_GET, 32'hffff_ffff, 32'h0);
    send_request(OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_GET, 32'h0000_1234, 32'h0);
    // zero capacity acts as one, now below occupancy: new keys replace the oldest only
    write_capacity(cap_t'(0));
    send_request(OP_PUT, 32'h0000_0055, 32'h5555_aaaa);
    send_request(OP_GET, 32'h7fff_ffff, 32'h0);
    send_request(OP_GET, 32'h0000_0055, 32'h0);
    send_request(OP_PUT, 32'h0000_0066, 32'haaaa_5555);
    send_request(OP_GET, 32'hffff_ffff, 32'h0);
    send_request(OP_GET, 32'h0000_0066, 32'h0);
    // above depth saturates
    write_capacity(cap_t'(31));
    send_request(OP_PUT, 32'h0000_0077, 32'h0f0f_f0f0);
    send_request(OP_GET, 32'h0000_0077, 32'h0);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
  endtask

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_replies) begin
        stall_left   = LONG_HOLD;
        hold_replies = 1'b0;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      rsp_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) mirror.check_reply(rsp_if.found, rsp_if.read_value);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("lru_key_value_cache_tb: FAIL");
    $finish;
  end

  initial begin
    mirror                 = new();
    steady                 = 1'b0;
    hold_replies           = 1'b0;
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.operation       = OP_GET;
    req_if.lookup_key      = '0;
    req_if.store_value     = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.capacity_in_use = CAP_RESET;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        if (p == 2 && n == 10) hold_replies = 1'b1;
        if (p == 4 && n == 75) drain_replies();
        send_random();
      end
    end

    drain_replies();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("lru_key_value_cache_tb: PASS");
    end else begin
      $display("lru_key_value_cache_tb: FAIL");
    end
    $finish;
  end

endmodule
